### design/ken_pkg.sv
package ken_pkg;

	// Queue sizing
	localparam int DEF_QUEUE_SLOTS = 128;
	localparam int CMD_DEPTH       = 2;
	localparam int COUNT_W         = 7;
	localparam int DROP_W          = 32;

	// Event kinds as carried on the input channel
	localparam logic [1:0] KIND_KEY     = 2'd0;
	localparam logic [1:0] KIND_POINTER = 2'd1;

	// HID usage codes
	localparam logic [7:0] KEY_NONE    = 8'h00;
	localparam logic [7:0] KEY_DELETE  = 8'h4C;
	localparam logic [7:0] KEY_CAPS    = 8'h39;
	localparam logic [7:0] KEY_NUM     = 8'h53;
	localparam logic [7:0] KEY_SCROLL  = 8'h47;
	localparam logic [4:0] KEY_MOD_HI  = 5'b11100;

	// Modifier groups in HID bit order
	localparam logic [7:0] CTRL_MOD_BITS = 8'h11;
	localparam logic [7:0] ALT_MOD_BITS  = 8'h44;

	// Lock bits
	localparam logic [2:0] LOCK_NONE   = 3'b000;
	localparam logic [2:0] LOCK_CAPS   = 3'b001;
	localparam logic [2:0] LOCK_NUM    = 3'b010;
	localparam logic [2:0] LOCK_SCROLL = 3'b100;

	typedef enum logic [1:0] {
		MODE_SUBMIT = 2'd0,
		MODE_POP    = 2'd1,
		MODE_TAKE   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REPORT = 2'd2
	} cmd_op_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_POP  = 1'b1
	} bk_state_t;

	// Stored event, 24 bits
	typedef struct packed {
		logic [2:0] buttons;
		logic [2:0] locks;
		logic [7:0] mods;
		logic       pressed;
		logic [7:0] code;
		logic       kind;
	} entry_t;

	// Classified item handed from front to back
	typedef struct packed {
		cmd_op_t op;
		entry_t  entry;
		logic    reset_pulse;
		logic    action_taken;
	} cmd_t;

	// Result register contents
	typedef struct packed {
		logic               accepted;
		logic               pop_valid;
		logic               out_kind;
		logic [7:0]         out_code;
		logic               out_pressed;
		logic [7:0]         out_modifiers;
		logic [2:0]         out_locks;
		logic [2:0]         out_buttons;
		logic [COUNT_W-1:0] pending_count;
		logic [DROP_W-1:0]  dropped_count;
		logic               reset_pulse;
		logic               action_taken;
	} res_t;

endpackage

### design/ken_in_if.sv
interface ken_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [1:0] event_kind;
	logic [7:0] key_code;
	logic [1:0] key_state;
	logic [7:0] pointer_buttons;

	modport source(output valid, mode, event_kind, key_code, key_state, pointer_buttons,
		input ready);
	modport sink(input valid, mode, event_kind, key_code, key_state, pointer_buttons,
		output ready);
endinterface

### design/ken_out_if.sv
interface ken_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic        pop_valid;
	logic        out_kind;
	logic [7:0]  out_code;
	logic        out_pressed;
	logic [7:0]  out_modifiers;
	logic [2:0]  out_locks;
	logic [2:0]  out_buttons;
	logic [6:0]  pending_count;
	logic [31:0] dropped_count;
	logic        reset_pulse;
	logic        action_taken;

	modport source(output valid, accepted, pop_valid, out_kind, out_code, out_pressed,
		out_modifiers, out_locks, out_buttons, pending_count, dropped_count,
		reset_pulse, action_taken, input ready);
	modport sink(input valid, accepted, pop_valid, out_kind, out_code, out_pressed,
		out_modifiers, out_locks, out_buttons, pending_count, dropped_count,
		reset_pulse, action_taken, output ready);
endinterface

### design/ken_front.sv
module ken_front (
	input  logic           clk,
	input  logic           arst_n,
	ken_in_if.sink         in_ch,
	output ken_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);

	logic [7:0] mods_q;
	logic [2:0] locks_q;
	logic       rst_pend_q;

	ken_pkg::mode_t mode;
	logic           xfer;
	logic           key_ok;
	logic           ptr_ok;
	logic           pressed;
	logic [7:0]     mod_mask;
	logic [2:0]     lock_mask;
	logic [7:0]     mods_new;
	logic [2:0]     locks_new;
	logic           chord;
	ken_pkg::entry_t entry;

	assign mode      = ken_pkg::mode_t'(in_ch.mode);
	assign in_ch.ready = cmd_ready;
	assign cmd_valid = in_ch.valid;
	assign xfer      = in_ch.valid && cmd_ready;

	// Check the submitted event
	always_comb begin
		key_ok  = (in_ch.event_kind == ken_pkg::KIND_KEY) &&
			(in_ch.key_code != ken_pkg::KEY_NONE) && !in_ch.key_state[1];
		ptr_ok  = (in_ch.event_kind == ken_pkg::KIND_POINTER) &&
			(in_ch.pointer_buttons[7:3] == 5'd0);
		pressed = in_ch.key_state[0];
	end

	// Decode modifier and lock keys
	always_comb begin
		if (in_ch.key_code[7:3] == ken_pkg::KEY_MOD_HI) begin
			mod_mask = 8'd1 << in_ch.key_code[2:0];
		end else begin
			mod_mask = 8'd0;
		end
		case (in_ch.key_code)
			ken_pkg::KEY_CAPS:   lock_mask = ken_pkg::LOCK_CAPS;
			ken_pkg::KEY_NUM:    lock_mask = ken_pkg::LOCK_NUM;
			ken_pkg::KEY_SCROLL: lock_mask = ken_pkg::LOCK_SCROLL;
			default:             lock_mask = ken_pkg::LOCK_NONE;
		endcase
	end

	// Update key state and detect the reset chord
	always_comb begin
		mods_new  = mods_q;
		locks_new = locks_q;
		if (key_ok) begin
			if (pressed) begin
				mods_new  = mods_q | mod_mask;
				locks_new = locks_q ^ lock_mask;
			end else begin
				mods_new  = mods_q & ~mod_mask;
			end
		end
		chord = key_ok && pressed && (in_ch.key_code == ken_pkg::KEY_DELETE) &&
			((mods_new & ken_pkg::CTRL_MOD_BITS) != 8'd0) &&
			((mods_new & ken_pkg::ALT_MOD_BITS) != 8'd0);
	end

	// Build the normalized event
	always_comb begin
		entry = '0;
		if (key_ok) begin
			entry.code    = in_ch.key_code;
			entry.pressed = pressed;
			entry.mods    = mods_new;
			entry.locks   = locks_new;
		end else begin
			entry.kind    = 1'b1;
			entry.buttons = in_ch.pointer_buttons[2:0];
		end
	end

	// Classify the item for the back end
	always_comb begin
		cmd              = '0;
		cmd.op           = ken_pkg::CMD_REPORT;
		cmd.entry        = entry;
		case (mode)
			ken_pkg::MODE_SUBMIT: begin
				cmd.op          = (key_ok || ptr_ok) ? ken_pkg::CMD_PUSH : ken_pkg::CMD_REPORT;
				cmd.reset_pulse = chord;
			end
			ken_pkg::MODE_POP: begin
				cmd.op = ken_pkg::CMD_POP;
			end
			ken_pkg::MODE_TAKE: begin
				cmd.action_taken = rst_pend_q;
			end
			default: begin
				cmd.op = ken_pkg::CMD_REPORT;
			end
		endcase
	end

	// Hold modifier, lock and pending reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q     <= '0;
			locks_q    <= '0;
			rst_pend_q <= 1'b0;
		end else if (xfer) begin
			if (mode == ken_pkg::MODE_SUBMIT) begin
				mods_q  <= mods_new;
				locks_q <= locks_new;
				if (chord) begin
					rst_pend_q <= 1'b1;
				end
			end else if (mode == ken_pkg::MODE_TAKE) begin
				rst_pend_q <= 1'b0;
			end
		end
	end

endmodule

### design/ken_cmd_fifo.sv
module ken_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ken_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ken_pkg::cmd_t pop_cmd
);

	localparam int PW = (ken_pkg::CMD_DEPTH > 1) ? $clog2(ken_pkg::CMD_DEPTH) : 1;
	localparam int CW = $clog2(ken_pkg::CMD_DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(ken_pkg::CMD_DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(ken_pkg::CMD_DEPTH);

	ken_pkg::cmd_t slot_q [ken_pkg::CMD_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          wr_en;
	logic          rd_en;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = slot_q[rd_q];
	assign wr_en      = push_valid && push_ready;
	assign rd_en      = pop_valid && pop_ready;

	// Store incoming commands
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/ken_back.sv
module ken_back #(
	parameter int QUEUE_SLOTS = ken_pkg::DEF_QUEUE_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ken_pkg::cmd_t cmd,
	ken_out_if.source     out_ch
);

	localparam int PW = $clog2(QUEUE_SLOTS);
	localparam logic [PW-1:0] LAST  = PW'(QUEUE_SLOTS - 1);
	localparam logic [PW:0]   SLOTS = (PW+1)'(QUEUE_SLOTS);

	ken_pkg::entry_t mem [QUEUE_SLOTS];
	ken_pkg::entry_t rdata_q;
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [ken_pkg::DROP_W-1:0] drop_q;
	ken_pkg::bk_state_t state_q;
	ken_pkg::bk_state_t state_d;
	logic            out_valid_q;
	ken_pkg::res_t   res_q;

	logic            take;
	logic            full;
	logic            empty;
	logic            push_ok;
	logic            pop_rd;
	logic [PW-1:0]   wr_nx;
	logic [PW-1:0]   rd_nx;
	logic [ken_pkg::DROP_W-1:0] drop_nx;
	logic [PW:0]     depth;
	logic            load;
	ken_pkg::res_t   res;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	assign cmd_ready = (state_q == ken_pkg::BK_IDLE) && (!out_valid_q || out_ch.ready);
	assign take      = cmd_valid && cmd_ready;
	assign full      = (next_ptr(wr_q) == rd_q);
	assign empty     = (wr_q == rd_q);
	assign push_ok   = take && (cmd.op == ken_pkg::CMD_PUSH) && !full;
	assign pop_rd    = take && (cmd.op == ken_pkg::CMD_POP) && !empty;

	// Pointer and drop counter updates
	always_comb begin
		wr_nx   = push_ok ? next_ptr(wr_q) : wr_q;
		rd_nx   = pop_rd ? next_ptr(rd_q) : rd_q;
		drop_nx = drop_q;
		if (take && (cmd.op == ken_pkg::CMD_PUSH) && full && (drop_q != '1)) begin
			drop_nx = drop_q + 1'b1;
		end
		if (wr_nx >= rd_nx) begin
			depth = {1'b0, wr_nx} - {1'b0, rd_nx};
		end else begin
			depth = {1'b0, wr_nx} + SLOTS - {1'b0, rd_nx};
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ken_pkg::BK_IDLE: begin
				if (pop_rd) begin
					state_d = ken_pkg::BK_POP;
				end
			end
			ken_pkg::BK_POP: begin
				state_d = ken_pkg::BK_IDLE;
			end
			default: begin
				state_d = ken_pkg::BK_IDLE;
			end
		endcase
	end

	// Result contents
	always_comb begin
		res               = '0;
		res.pending_count = ken_pkg::COUNT_W'(depth);
		res.dropped_count = drop_nx;
		load              = 1'b0;
		case (state_q)
			ken_pkg::BK_IDLE: begin
				load = take && !pop_rd;
				case (cmd.op)
					ken_pkg::CMD_PUSH: begin
						res.accepted    = !full;
						res.reset_pulse = cmd.reset_pulse;
					end
					ken_pkg::CMD_REPORT: begin
						res.reset_pulse  = cmd.reset_pulse;
						res.action_taken = cmd.action_taken;
					end
					default: begin
						res.accepted = 1'b0;
					end
				endcase
			end
			ken_pkg::BK_POP: begin
				load          = 1'b1;
				res.pop_valid = 1'b1;
				res.out_kind  = rdata_q.kind;
				if (rdata_q.kind) begin
					res.out_buttons = rdata_q.buttons;
				end else begin
					res.out_code      = rdata_q.code;
					res.out_pressed   = rdata_q.pressed;
					res.out_modifiers = rdata_q.mods;
					res.out_locks     = rdata_q.locks;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Event memory
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_q] <= cmd.entry;
		end
		if (pop_rd) begin
			rdata_q <= mem[rd_q];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			drop_q      <= '0;
			state_q     <= ken_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			wr_q    <= wr_nx;
			rd_q    <= rd_nx;
			drop_q  <= drop_nx;
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.accepted      = res_q.accepted;
	assign out_ch.pop_valid     = res_q.pop_valid;
	assign out_ch.out_kind      = res_q.out_kind;
	assign out_ch.out_code      = res_q.out_code;
	assign out_ch.out_pressed   = res_q.out_pressed;
	assign out_ch.out_modifiers = res_q.out_modifiers;
	assign out_ch.out_locks     = res_q.out_locks;
	assign out_ch.out_buttons   = res_q.out_buttons;
	assign out_ch.pending_count = res_q.pending_count;
	assign out_ch.dropped_count = res_q.dropped_count;
	assign out_ch.reset_pulse   = res_q.reset_pulse;
	assign out_ch.action_taken  = res_q.action_taken;

endmodule

### design/key_event_normalizer_fifo.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   mode, event_kind, key_code, key_state, pointer_buttons
// out_ch    out  valid/ready   accepted, pop_valid, popped event, counts, reset_pulse,
//                              action_taken
//
// Submit, take and empty pops load their result from the idle state in the back end;
// a returned event first passes the pop state, for the registered event memory read.
// Reset clears pointers, drop counter, modifier, lock and pending reset state at once;
// the event memory is not cleared, since only written slots are ever read.
// A two-entry command queue sits between front and back, and the result register
// lets the back end take the next command in the cycle its result transfers.
module key_event_normalizer_fifo #(
	parameter int QUEUE_SLOTS = ken_pkg::DEF_QUEUE_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	ken_in_if.sink    in_ch,
	ken_out_if.source out_ch
);

	ken_pkg::cmd_t fr_cmd;
	logic          fr_valid;
	logic          fr_ready;
	ken_pkg::cmd_t bk_cmd;
	logic          bk_valid;
	logic          bk_ready;

	ken_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd       (fr_cmd),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready)
	);

	ken_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_cmd   (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_cmd    (bk_cmd)
	);

	ken_back #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.out_ch    (out_ch)
	);

	// A result is never both a queued submit and a returned event
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.accepted && out_ch.pop_valid))
		else $error("submit and pop flagged in one result");

	// The reset pulse and the action report come from different modes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.reset_pulse && out_ch.action_taken))
		else $error("reset pulse and action taken in one result");

	// Event fields stay clear unless an event was popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.pop_valid) |->
		(out_ch.out_kind == 1'b0 && out_ch.out_code == 8'd0 &&
		out_ch.out_modifiers == 8'd0 && out_ch.out_locks == 3'd0 &&
		out_ch.out_buttons == 3'd0 && out_ch.out_pressed == 1'b0))
		else $error("event fields set without a popped event");

	// Hold a waiting result steady until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=>
		(out_ch.valid && $stable(out_ch.pending_count) && $stable(out_ch.dropped_count) &&
		$stable(out_ch.accepted) && $stable(out_ch.pop_valid)))
		else $error("result changed while waiting for its transfer");

endmodule
